// File: rtl/camu_pkg.sv
// ----------------------------------------------------------------------------
// camu_pkg: shared types for the addressing mode unit
// Mode, request kind and read step codes, plus the state and payload structs.
// ----------------------------------------------------------------------------
package camu_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } t_op;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IMP = 4'd0,
        MODE_IMM = 4'd1,
        MODE_ZP0 = 4'd2,
        MODE_ZPX = 4'd3,
        MODE_ZPY = 4'd4,
        MODE_ABS = 4'd5,
        MODE_ABX = 4'd6,
        MODE_ABY = 4'd7,
        MODE_IND = 4'd8,
        MODE_IZX = 4'd9,
        MODE_IZY = 4'd10,
        MODE_REL = 4'd11
    } t_mode;

    // which operand or pointer byte the next returning read carries
    typedef enum logic [1:0] {
        STEP_FIRST  = 2'd0,
        STEP_SECOND = 2'd1,
        STEP_THIRD  = 2'd2,
        STEP_FOURTH = 2'd3
    } t_step;

    localparam logic [15:0] PAGE_MASK = 16'hFF00;
    localparam logic [15:0] ZP_MASK   = 16'h00FF;
    localparam logic [7:0]  SIGN_BIT  = 8'h80;

    typedef struct packed {
        logic        busy;
        t_mode       active_mode;
        t_step       read_step;
        logic [15:0] current_pc;
        logic [7:0]  saved_x;
        logic [7:0]  saved_y;
        logic [7:0]  operand_low;
        logic [7:0]  operand_high;
        logic [7:0]  pointer_low_byte;
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [3:0]  mode;
        logic [15:0] program_counter;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  accumulator;
        logic [7:0]  read_data;
    } t_req;

    typedef struct packed {
        t_kind       result_kind;
        logic [15:0] read_address;
        logic [15:0] effective_address;
        logic [15:0] relative_offset;
        logic [15:0] next_pc;
        logic [7:0]  fetched_value;
        logic        fetched_valid;
        logic        page_crossed;
        logic        protocol_error;
    } t_res;

endpackage

// File: rtl/camu_if.sv
// ----------------------------------------------------------------------------
// camu_if: request and result channels of the addressing mode unit
// Valid/ready handshake; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface camu_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [3:0]  mode;
    logic [15:0] program_counter;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  accumulator;
    logic [7:0]  read_data;

    modport source (
        output valid, operation, mode, program_counter, index_x, index_y,
               accumulator, read_data,
        input  ready
    );
    modport sink (
        input  valid, operation, mode, program_counter, index_x, index_y,
               accumulator, read_data,
        output ready
    );
endinterface

interface camu_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] read_address;
    logic [15:0] effective_address;
    logic [15:0] relative_offset;
    logic [15:0] next_pc;
    logic [7:0]  fetched_value;
    logic        fetched_valid;
    logic        page_crossed;
    logic        protocol_error;

    modport source (
        output valid, result_kind, read_address, effective_address,
               relative_offset, next_pc, fetched_value, fetched_valid,
               page_crossed, protocol_error,
        input  ready
    );
    modport sink (
        input  valid, result_kind, read_address, effective_address,
               relative_offset, next_pc, fetched_value, fetched_valid,
               page_crossed, protocol_error,
        output ready
    );
endinterface

// File: rtl/camu_step.sv
// ----------------------------------------------------------------------------
// camu_step: one addressing step
// Next sequencer state and the result for one request, purely combinational.
// ----------------------------------------------------------------------------
module camu_step (
    input  camu_pkg::t_state i_state,
    input  camu_pkg::t_req   i_req,
    output camu_pkg::t_state o_state,
    output camu_pkg::t_res   o_res
);

    logic [7:0]  d;
    logic [7:0]  opl;
    logic [15:0] pc1;
    logic [15:0] pc2;
    logic [15:0] base;
    logic [15:0] ptr;
    logic [15:0] ea_idx;
    logic [15:0] ea_izy;
    logic [7:0]  zp_idx;
    logic        first;

    assign d     = i_req.read_data;
    assign first = (i_state.read_step == camu_pkg::STEP_FIRST);
    assign opl   = first ? d : i_state.operand_low;
    assign pc1   = first ? i_state.current_pc + 16'd1 : i_state.current_pc;
    assign pc2   = pc1 + 16'd1;
    assign base  = {d, opl};
    assign ptr   = {i_state.operand_high, opl};
    assign ea_idx = base + {8'h00, (i_state.active_mode == camu_pkg::MODE_ABX)
                                   ? i_state.saved_x : i_state.saved_y};
    assign ea_izy = {d, i_state.pointer_low_byte} + {8'h00, i_state.saved_y};
    assign zp_idx = opl + i_state.saved_x;

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        if (i_req.operation == camu_pkg::OP_START) begin
            if (i_state.busy) begin
                o_res.protocol_error = 1'b1;
            end else if (i_req.mode > camu_pkg::MODE_REL) begin
                o_res.result_kind    = camu_pkg::KIND_DONE;
                o_res.next_pc        = i_req.program_counter;
                o_res.protocol_error = 1'b1;
            end else begin
                o_state.active_mode = camu_pkg::t_mode'(i_req.mode);
                o_state.current_pc  = i_req.program_counter;
                o_state.saved_x     = i_req.index_x;
                o_state.saved_y     = i_req.index_y;
                o_state.read_step   = camu_pkg::STEP_FIRST;
                if (i_req.mode == camu_pkg::MODE_IMP) begin
                    o_res.result_kind   = camu_pkg::KIND_DONE;
                    o_res.next_pc       = i_req.program_counter;
                    o_res.fetched_value = i_req.accumulator;
                    o_res.fetched_valid = 1'b1;
                end else if (i_req.mode == camu_pkg::MODE_IMM) begin
                    o_res.result_kind       = camu_pkg::KIND_DONE;
                    o_res.effective_address = i_req.program_counter;
                    o_res.next_pc           = i_req.program_counter + 16'd1;
                end else begin
                    o_state.busy       = 1'b1;
                    o_res.result_kind  = camu_pkg::KIND_READ;
                    o_res.read_address = i_req.program_counter;
                end
            end
        end else if (!i_state.busy) begin
            o_res.protocol_error = 1'b1;
        end else begin
            o_state.operand_low = opl;
            o_state.current_pc  = pc1;
            // request arms overwrite this; finishing arms keep it
            o_res.result_kind   = camu_pkg::KIND_DONE;
            o_res.next_pc       = pc1;
            case (i_state.active_mode)
                camu_pkg::MODE_ZP0: begin
                    o_res.effective_address = {8'h00, d};
                end
                camu_pkg::MODE_ZPX: begin
                    o_res.effective_address = {8'h00, d + i_state.saved_x};
                end
                camu_pkg::MODE_ZPY: begin
                    o_res.effective_address = {8'h00, d + i_state.saved_y};
                end
                camu_pkg::MODE_REL: begin
                    o_res.relative_offset = {{8{(d & camu_pkg::SIGN_BIT) != 8'h00}}, d};
                end
                camu_pkg::MODE_ABS, camu_pkg::MODE_ABX, camu_pkg::MODE_ABY: begin
                    if (first) begin
                        o_state.read_step  = camu_pkg::STEP_SECOND;
                        o_res.result_kind  = camu_pkg::KIND_READ;
                        o_res.read_address = pc1;
                        o_res.next_pc      = '0;
                    end else begin
                        o_state.operand_high = d;
                        o_state.current_pc   = pc2;
                        o_res.next_pc        = pc2;
                        if (i_state.active_mode == camu_pkg::MODE_ABS) begin
                            o_res.effective_address = base;
                        end else begin
                            o_res.effective_address = ea_idx;
                            o_res.page_crossed      = (ea_idx[15:8] != d);
                        end
                    end
                end
                camu_pkg::MODE_IND: begin
                    case (i_state.read_step)
                        camu_pkg::STEP_FIRST: begin
                            o_state.read_step  = camu_pkg::STEP_SECOND;
                            o_res.result_kind  = camu_pkg::KIND_READ;
                            o_res.read_address = pc1;
                            o_res.next_pc      = '0;
                        end
                        camu_pkg::STEP_SECOND: begin
                            o_state.operand_high = d;
                            o_state.current_pc   = pc2;
                            o_state.read_step    = camu_pkg::STEP_THIRD;
                            o_res.result_kind    = camu_pkg::KIND_READ;
                            o_res.read_address   = base;
                            o_res.next_pc        = '0;
                        end
                        camu_pkg::STEP_THIRD: begin
                            o_state.pointer_low_byte = d;
                            o_state.read_step        = camu_pkg::STEP_FOURTH;
                            o_res.result_kind        = camu_pkg::KIND_READ;
                            o_res.next_pc            = '0;
                            // pointer high byte wraps inside its page
                            if (opl == 8'hFF) begin
                                o_res.read_address = ptr & camu_pkg::PAGE_MASK;
                            end else begin
                                o_res.read_address = ptr + 16'd1;
                            end
                        end
                        default: begin
                            o_res.effective_address = {d, i_state.pointer_low_byte};
                        end
                    endcase
                end
                camu_pkg::MODE_IZX: begin
                    case (i_state.read_step)
                        camu_pkg::STEP_FIRST: begin
                            o_state.read_step  = camu_pkg::STEP_SECOND;
                            o_res.result_kind  = camu_pkg::KIND_READ;
                            o_res.read_address = {8'h00, zp_idx};
                            o_res.next_pc      = '0;
                        end
                        camu_pkg::STEP_SECOND: begin
                            o_state.pointer_low_byte = d;
                            o_state.read_step        = camu_pkg::STEP_THIRD;
                            o_res.result_kind        = camu_pkg::KIND_READ;
                            o_res.read_address       = {8'h00, zp_idx + 8'd1};
                            o_res.next_pc            = '0;
                        end
                        default: begin
                            o_res.effective_address = {d, i_state.pointer_low_byte};
                        end
                    endcase
                end
                camu_pkg::MODE_IZY: begin
                    case (i_state.read_step)
                        camu_pkg::STEP_FIRST: begin
                            o_state.read_step  = camu_pkg::STEP_SECOND;
                            o_res.result_kind  = camu_pkg::KIND_READ;
                            o_res.read_address = {8'h00, opl} & camu_pkg::ZP_MASK;
                            o_res.next_pc      = '0;
                        end
                        camu_pkg::STEP_SECOND: begin
                            o_state.pointer_low_byte = d;
                            o_state.read_step        = camu_pkg::STEP_THIRD;
                            o_res.result_kind        = camu_pkg::KIND_READ;
                            o_res.read_address       = {8'h00, opl + 8'd1};
                            o_res.next_pc            = '0;
                        end
                        default: begin
                            o_res.effective_address = ea_izy;
                            o_res.page_crossed      = (ea_izy[15:8] != d);
                        end
                    endcase
                end
                default: begin
                    // implied and immediate never leave the unit busy
                end
            endcase
            if (o_res.result_kind == camu_pkg::KIND_DONE) begin
                o_state.busy      = 1'b0;
                o_state.read_step = camu_pkg::STEP_FIRST;
            end
        end
    end

endmodule

// File: rtl/camu_out_reg.sv
// ----------------------------------------------------------------------------
// camu_out_reg: result register
// Hold one result until taken; load a new one in the cycle the old one leaves.
// ----------------------------------------------------------------------------
module camu_out_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  camu_pkg::t_res  i_res,
    output logic            o_free,
    camu_out_if.source      o_out
);

    logic           r_valid;
    logic           n_valid;
    camu_pkg::t_res r_res;

    assign o_free  = !r_valid || o_out.ready;
    assign n_valid = i_load || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid             = r_valid;
    assign o_out.result_kind       = r_res.result_kind;
    assign o_out.read_address      = r_res.read_address;
    assign o_out.effective_address = r_res.effective_address;
    assign o_out.relative_offset   = r_res.relative_offset;
    assign o_out.next_pc           = r_res.next_pc;
    assign o_out.fetched_value     = r_res.fetched_value;
    assign o_out.fetched_valid     = r_res.fetched_valid;
    assign o_out.page_crossed      = r_res.page_crossed;
    assign o_out.protocol_error    = r_res.protocol_error;

endmodule

// File: rtl/cpu_addressing_mode_unit.sv
// ----------------------------------------------------------------------------
// cpu_addressing_mode_unit: effective-address sequencer for 6502 addressing
// A result is registered when its request is accepted and shows in the next cycle.
// Throughput: one request per cycle; the result register is reloaded in the
// same cycle its current result is taken, so only a stalled output stops input.
// Reset (synchronous, active low) clears the sequencer state and empties the
// result register.
// ----------------------------------------------------------------------------
module cpu_addressing_mode_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    camu_in_if.sink    i_in,
    camu_out_if.source o_out
);

    // Sequencer state: busy flag, latched mode and indexes, operand bytes.
    camu_pkg::t_state r_state;
    camu_pkg::t_state n_state;
    camu_pkg::t_req   req;
    camu_pkg::t_res   res;
    logic             out_free;
    logic             accept;

    // Gather the request fields into one word for the step logic.
    assign req.operation       = camu_pkg::t_op'(i_in.operation);
    assign req.mode            = i_in.mode;
    assign req.program_counter = i_in.program_counter;
    assign req.index_x         = i_in.index_x;
    assign req.index_y         = i_in.index_y;
    assign req.accumulator     = i_in.accumulator;
    assign req.read_data       = i_in.read_data;

    // Take a request whenever the result register has room for its answer.
    assign i_in.ready = out_free;
    assign accept     = i_in.valid && out_free;

    // Every request yields exactly one result, computed in the same cycle.
    camu_step u_step (
        .i_state (r_state),
        .i_req   (req),
        .o_state (n_state),
        .o_res   (res)
    );

    // Advance the sequencer only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result register toward the bus and the core.
    camu_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

`ifndef SYNTH
    // An ignored request must leave the sequencer untouched.
    a_error_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res.protocol_error) |=> (r_state == $past(r_state)))
        else $error("ignored request changed sequencer state");

    // A bus read request keeps the sequencer busy for the returning byte.
    a_read_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !res.protocol_error && res.result_kind == camu_pkg::KIND_READ)
        |=> r_state.busy)
        else $error("read request issued but sequencer not busy");

    // A finished result returns the sequencer to idle.
    a_done_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res.result_kind == camu_pkg::KIND_DONE) |=> !r_state.busy)
        else $error("sequencer still busy after finishing");

    // An idle sequencer always waits for the first operand byte.
    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.busy |-> (r_state.read_step == camu_pkg::STEP_FIRST))
        else $error("idle sequencer has a pending read step");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 6502 addressing mode sequencer
// Drives start and read-data requests, answers the unit's bus reads with
// random bytes, and checks every result against a cycle-free model of the
// twelve addressing modes kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;
    import camu_pkg::*;

    // Mode codes past the end of the table; the unit must reject them.
    localparam logic [3:0] MODE_BAD_LOW  = 4'd12;
    localparam logic [3:0] MODE_BAD_HIGH = 4'd15;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the sequencer state, predicts one result per
    // accepted request and holds the predictions until the unit answers.
    // ------------------------------------------------------------------------
    class address_scoreboard;
        t_res        awaited_results[$];
        int unsigned errors;

        logic        busy;
        t_mode       mode;
        t_step       byte_step;
        logic [15:0] pc;
        logic [7:0]  idx_x;
        logic [7:0]  idx_y;
        logic [7:0]  op_lo;
        logic [7:0]  op_hi;
        logic [7:0]  ptr_lo;

        function new();
            errors    = 0;
            busy      = 1'b0;
            mode      = MODE_IMP;
            byte_step = STEP_FIRST;
            pc        = '0;
            idx_x     = '0;
            idx_y     = '0;
            op_lo     = '0;
            op_hi     = '0;
            ptr_lo    = '0;
        endfunction

        task report(string what);
            $display("mismatch @%0t: %s", $time, what);
            errors++;
        endtask

        // Close the current decode: fill the done fields and go idle.
        function t_res complete(t_res r, logic [15:0] ea, logic [15:0] rel,
                                logic [15:0] npc, logic page);
            r.result_kind       = KIND_DONE;
            r.effective_address = ea;
            r.relative_offset   = rel;
            r.next_pc           = npc;
            r.page_crossed      = page;
            busy                = 1'b0;
            byte_step           = STEP_FIRST;
            return r;
        endfunction

        // One returned bus byte while a decode is in flight.
        function t_res advance(logic [7:0] d);
            t_res        r;
            logic [15:0] base;
            logic [15:0] ea;
            logic [7:0]  idx;
            logic [7:0]  zp;
            r = '0;
            if (byte_step == STEP_FIRST) begin
                op_lo = d;
                pc    = pc + 16'd1;
            end
            idx = (mode == MODE_ABX || mode == MODE_ZPX) ? idx_x : idx_y;
            case (mode)
                MODE_ZP0: begin
                    r = complete(r, {8'h00, d}, 16'h0000, pc, 1'b0);
                end
                MODE_ZPX, MODE_ZPY: begin
                    zp = d + idx;   // wraps inside page zero
                    r = complete(r, {8'h00, zp}, 16'h0000, pc, 1'b0);
                end
                MODE_REL: begin
                    r = complete(r, 16'h0000,
                                 ((d & SIGN_BIT) != 0) ? {8'hFF, d} : {8'h00, d},
                                 pc, 1'b0);
                end
                MODE_ABS, MODE_ABX, MODE_ABY: begin
                    if (byte_step == STEP_FIRST) begin
                        byte_step      = STEP_SECOND;
                        r.read_address = pc;
                    end else begin
                        op_hi = d;
                        pc    = pc + 16'd1;
                        base  = {op_hi, op_lo};
                        if (mode == MODE_ABS) begin
                            r = complete(r, base, 16'h0000, pc, 1'b0);
                        end else begin
                            // index goes onto the full 16-bit address
                            ea = base + {8'h00, idx};
                            r = complete(r, ea, 16'h0000, pc, ea[15:8] != op_hi);
                        end
                    end
                end
                MODE_IND: begin
                    base = {op_hi, op_lo};
                    case (byte_step)
                        STEP_FIRST: begin
                            byte_step      = STEP_SECOND;
                            r.read_address = pc;
                        end
                        STEP_SECOND: begin
                            op_hi          = d;
                            pc             = pc + 16'd1;
                            byte_step      = STEP_THIRD;
                            r.read_address = {op_hi, op_lo};
                        end
                        STEP_THIRD: begin
                            ptr_lo    = d;
                            byte_step = STEP_FOURTH;
                            // pointer high byte never leaves the pointer's page
                            r.read_address = (op_lo == 8'hFF) ? (base & PAGE_MASK)
                                                              : base + 16'd1;
                        end
                        default: begin
                            r = complete(r, {d, ptr_lo}, 16'h0000, pc, 1'b0);
                        end
                    endcase
                end
                MODE_IZX: begin
                    case (byte_step)
                        STEP_FIRST: begin
                            byte_step      = STEP_SECOND;
                            r.read_address = ({8'h00, op_lo} + idx_x) & ZP_MASK;
                        end
                        STEP_SECOND: begin
                            ptr_lo         = d;
                            byte_step      = STEP_THIRD;
                            r.read_address = ({8'h00, op_lo} + idx_x + 16'd1) & ZP_MASK;
                        end
                        default: begin
                            r = complete(r, {d, ptr_lo}, 16'h0000, pc, 1'b0);
                        end
                    endcase
                end
                default: begin  // indirect indexed by Y
                    case (byte_step)
                        STEP_FIRST: begin
                            byte_step      = STEP_SECOND;
                            r.read_address = {8'h00, op_lo};
                        end
                        STEP_SECOND: begin
                            ptr_lo         = d;
                            byte_step      = STEP_THIRD;
                            r.read_address = ({8'h00, op_lo} + 16'd1) & ZP_MASK;
                        end
                        default: begin
                            ea = {d, ptr_lo} + {8'h00, idx_y};
                            r = complete(r, ea, 16'h0000, pc, ea[15:8] != d);
                        end
                    endcase
                end
            endcase
            return r;
        endfunction

        function void note_request(t_req q);
            t_res r;
            r = '0;
            if (q.operation == OP_START) begin
                if (busy) begin
                    r.protocol_error = 1'b1;
                end else if (q.mode > MODE_REL) begin
                    r.result_kind    = KIND_DONE;
                    r.next_pc        = q.program_counter;
                    r.protocol_error = 1'b1;
                end else begin
                    mode      = t_mode'(q.mode);
                    pc        = q.program_counter;
                    idx_x     = q.index_x;
                    idx_y     = q.index_y;
                    byte_step = STEP_FIRST;
                    if (mode == MODE_IMP) begin
                        r.fetched_value = q.accumulator;
                        r.fetched_valid = 1'b1;
                        r = complete(r, 16'h0000, 16'h0000, pc, 1'b0);
                    end else if (mode == MODE_IMM) begin
                        r = complete(r, pc, 16'h0000, pc + 16'd1, 1'b0);
                    end else begin
                        busy           = 1'b1;
                        r.read_address = pc;
                    end
                end
            end else if (!busy) begin
                r.protocol_error = 1'b1;
            end else begin
                r = advance(q.read_data);
            end
            awaited_results.push_back(r);
        endfunction

        task compare(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", field, got, want));
        endtask

        task check_result(t_res got);
            t_res w;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result, kind %0d", got.result_kind));
                return;
            end
            w = awaited_results.pop_front();
            compare("result_kind", 16'(got.result_kind), 16'(w.result_kind));
            compare("read_address", got.read_address, w.read_address);
            compare("effective_address", got.effective_address, w.effective_address);
            compare("relative_offset", got.relative_offset, w.relative_offset);
            compare("next_pc", got.next_pc, w.next_pc);
            compare("fetched_value", 16'(got.fetched_value), 16'(w.fetched_value));
            compare("fetched_valid", 16'(got.fetched_valid), 16'(w.fetched_valid));
            compare("page_crossed", 16'(got.page_crossed), 16'(w.page_crossed));
            compare("protocol_error", 16'(got.protocol_error),
                    16'(w.protocol_error));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the unit under test
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    camu_in_if  in_if ();
    camu_out_if out_if ();

    cpu_addressing_mode_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    address_scoreboard sb;
    int unsigned       src_idle;    // percent of cycles the sender holds off
    int unsigned       sink_idle;   // percent of cycles the receiver stalls
    int unsigned       good_items;  // requests sent inside well-formed decodes

    // Stall the result channel at random; change only on the falling edge.
    always @(negedge i_clk) begin
        out_if.ready = i_rst_n && ($urandom_range(99) >= sink_idle);
    end

    // Observe both channels at the rising edge. Any result seen here belongs
    // to a request accepted at an earlier edge, so the order of the two
    // checks inside the edge does not matter.
    always @(posedge i_clk) begin : monitor
        t_req q;
        t_res got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.result_kind       = t_kind'(out_if.result_kind);
            got.read_address      = out_if.read_address;
            got.effective_address = out_if.effective_address;
            got.relative_offset   = out_if.relative_offset;
            got.next_pc           = out_if.next_pc;
            got.fetched_value     = out_if.fetched_value;
            got.fetched_valid     = out_if.fetched_valid;
            got.page_crossed      = out_if.page_crossed;
            got.protocol_error    = out_if.protocol_error;
            sb.check_result(got);
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            q.operation       = t_op'(in_if.operation);
            q.mode            = in_if.mode;
            q.program_counter = in_if.program_counter;
            q.index_x         = in_if.index_x;
            q.index_y         = in_if.index_y;
            q.accumulator     = in_if.accumulator;
            q.read_data       = in_if.read_data;
            sb.note_request(q);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Favor the bytes that hit page and sign boundaries.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {rand_byte(), 8'hFF};
            default: return 16'($urandom);
        endcase
    endfunction

    // Bus bytes each mode consumes before it answers done.
    function automatic int unsigned operand_count(logic [3:0] m);
        case (m)
            MODE_ZP0, MODE_ZPX, MODE_ZPY, MODE_REL: return 1;
            MODE_ABS, MODE_ABX, MODE_ABY:           return 2;
            MODE_IZX, MODE_IZY:                     return 3;
            MODE_IND:                               return 4;
            default:                                return 0;
        endcase
    endfunction

    // Fill every field so that the unused ones toggle too.
    function automatic t_req any_request();
        t_req q;
        q.operation       = t_op'($urandom_range(1));
        q.mode            = 4'($urandom);
        q.program_counter = rand_word();
        q.index_x         = rand_byte();
        q.index_y         = rand_byte();
        q.accumulator     = rand_byte();
        q.read_data       = rand_byte();
        return q;
    endfunction

    // Present one request from a falling edge and hold it until accepted.
    // Valid stays high on return; callers that stop sending lower it.
    task automatic push(t_req q);
        while ($urandom_range(99) < src_idle) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid           = 1'b1;
        in_if.operation       = q.operation;
        in_if.mode            = q.mode;
        in_if.program_counter = q.program_counter;
        in_if.index_x         = q.index_x;
        in_if.index_y         = q.index_y;
        in_if.accumulator     = q.accumulator;
        in_if.read_data       = q.read_data;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic start_mode(logic [3:0] m, logic [15:0] pc_v, logic [7:0] x_v,
                              logic [7:0] y_v, logic [7:0] a_v);
        t_req q;
        q                 = any_request();
        q.operation       = OP_START;
        q.mode            = m;
        q.program_counter = pc_v;
        q.index_x         = x_v;
        q.index_y         = y_v;
        q.accumulator     = a_v;
        push(q);
    endtask

    task automatic feed(logic [7:0] d);
        t_req q;
        q           = any_request();
        q.operation = OP_DATA;
        q.read_data = d;
        push(q);
    endtask

    task automatic start_random(logic [3:0] m);
        start_mode(m, rand_word(), rand_byte(), rand_byte(), rand_byte());
    endtask

    // A complete decode: start, then exactly the bytes the mode asks for.
    task automatic well_formed();
        logic [3:0]  m;
        int unsigned n;
        m = 4'($urandom_range(MODE_REL));
        n = operand_count(m);
        start_random(m);
        repeat (n) feed(rand_byte());
        good_items += 1 + n;
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic drain();
        in_if.valid = 1'b0;
        while (sb.awaited_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic directed();
        feed(8'h5A);                                        // data while idle
        start_mode(MODE_IMP, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        start_mode(MODE_IMM, 16'hFFFF, 8'h00, 8'h00, 8'h00); // pc wraps
        start_mode(MODE_BAD_LOW, 16'hFFFF, 8'h00, 8'h00, 8'h00);
        start_mode(MODE_BAD_HIGH, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
        // zero-page index wraps inside page zero
        start_mode(MODE_ZPX, 16'h1234, 8'hFF, 8'h00, 8'h00);
        feed(8'hFF);
        // negative branch offset, pc wraps past the top
        start_mode(MODE_REL, 16'hFFFF, 8'h00, 8'h00, 8'h00);
        feed(8'h80);
        // absolute indexed carry into the high byte and past the top
        start_mode(MODE_ABX, 16'hFFFE, 8'h01, 8'h00, 8'h00);
        feed(8'hFF);
        feed(8'hFF);
        // indirect pointer at the end of a page: high byte from the same page
        start_mode(MODE_IND, 16'h0200, 8'h00, 8'h00, 8'h00);
        feed(8'hFF);
        feed(8'h12);
        feed(8'h34);
        feed(8'h56);
        // indirect indexed: pointer at the last zero-page byte, page crossed
        start_mode(MODE_IZY, 16'h0300, 8'h00, 8'hFF, 8'h00);
        feed(8'hFF);
        feed(8'h80);
        feed(8'h00);
        // start while busy is ignored, the open decode still completes
        start_mode(MODE_ZP0, 16'h4000, 8'h00, 8'h00, 8'h00);
        start_mode(MODE_IZX, 16'h5000, 8'h10, 8'h20, 8'h30);
        feed(8'h00);
    endtask

    // Mostly complete decodes with random content; the rest is noise and
    // broken sequences that the unit must flag and survive.
    task automatic random_traffic(int unsigned quota);
        int unsigned base_count;
        int unsigned k;
        int unsigned n;
        int unsigned cut;
        logic [3:0]  m;
        base_count = good_items;
        while (good_items - base_count < quota) begin
            k = $urandom_range(99);
            if (k < 80) begin
                well_formed();
            end else if (k < 86) begin
                feed(rand_byte());
            end else if (k < 90) begin
                start_random(4'($urandom_range(MODE_BAD_HIGH, MODE_BAD_LOW)));
            end else if (k < 96) begin
                // stray start dropped into the middle of a decode
                m   = 4'($urandom_range(MODE_REL, MODE_ZP0));
                n   = operand_count(m);
                cut = $urandom_range(n - 1);
                start_random(m);
                repeat (cut) feed(rand_byte());
                start_random(4'($urandom));
                repeat (n - cut) feed(rand_byte());
            end else begin
                // one byte too many
                well_formed();
                feed(rand_byte());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb                     = new();
        src_idle               = 0;
        sink_idle              = 0;
        good_items             = 0;
        i_rst_n                = 1'b0;
        in_if.valid            = 1'b0;
        in_if.operation        = OP_START;
        in_if.mode             = MODE_IMP;
        in_if.program_counter  = '0;
        in_if.index_x          = '0;
        in_if.index_y          = '0;
        in_if.accumulator      = '0;
        in_if.read_data        = '0;
        out_if.ready           = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Phase 1: receiver stalls heavily, sender idles lightly.
        src_idle  = 20;
        sink_idle = 82;
        directed();
        random_traffic(580);
        drain();    // sender holds off until the unit is fully drained

        // Phase 2: the other way round.
        src_idle  = 82;
        sink_idle = 20;
        random_traffic(580);
        drain();

        // Phase 3: back to back at full rate.
        src_idle  = 0;
        sink_idle = 0;
        random_traffic(580);
        drain();

        // Let any stray late result show up before judging.
        repeat (5) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this traffic.
    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
